// ----- sv/arv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the axis rotation block.
// Holds the opcode codes, fixed-point formats and Horner reciprocal tables.
// No dependencies.
package arv_pkg;

    localparam int ARV_ANGLE_BITS = 16;
    localparam int ARV_DATA_BITS  = 20;

    localparam int OP_W      = 2;
    localparam int NUM_LANES = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ROT_X = 2'd0,
        OP_ROT_Y = 2'd1,
        OP_ROT_Z = 2'd2,
        OP_PASS  = 2'd3
    } arv_op_t;

    // angle is widened to a 24-bit turn: 2 quadrant bits and a 22-bit offset
    localparam int TURN_BITS = 24;
    localparam int OFS_W     = TURN_BITS - 2;

    // unsigned Q1.30 series arithmetic, one extra bit so 1.0 fits
    localparam int QW   = 30;
    localparam int SC_W = QW + 1;
    localparam logic [SC_W-1:0] Q_ONE       = SC_W'(1) << QW;
    localparam logic [SC_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    // Q1.17 sine and cosine, signed, magnitude up to 1.0
    localparam int TRIG_FRAC = 17;
    localparam int MAG_W     = TRIG_FRAC + 1;
    localparam int TRIG_W    = TRIG_FRAC + 2;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(2 ** TRIG_FRAC);

    // pipeline depths
    localparam int TRIG_LAT = 13;
    localparam int LANE_LAT = 2;

    // floor(p / d) = (p * magic) >> shift for p < 2^31,
    // magic = ceil(2^(31 + ceil(log2 d)) / d)
    localparam int HORNER_STEPS = 4;

    localparam int SIN_SHIFT [HORNER_STEPS] = '{38, 37, 36, 34};
    localparam logic [31:0] SIN_MAGIC [HORNER_STEPS] = '{
        32'(((64'd1 << 38) + 64'd71) / 64'd72),
        32'(((64'd1 << 37) + 64'd41) / 64'd42),
        32'(((64'd1 << 36) + 64'd19) / 64'd20),
        32'(((64'd1 << 34) + 64'd5) / 64'd6)
    };

    localparam int COS_SHIFT [HORNER_STEPS] = '{38, 37, 36, 35};
    localparam logic [31:0] COS_MAGIC [HORNER_STEPS] = '{
        32'(((64'd1 << 38) + 64'd89) / 64'd90),
        32'(((64'd1 << 37) + 64'd55) / 64'd56),
        32'(((64'd1 << 36) + 64'd29) / 64'd30),
        32'(((64'd1 << 35) + 64'd11) / 64'd12)
    };

endpackage

// ----- sv/arv_sincos.sv -----
`timescale 1ns / 1ps
// Pipelined sine/cosine generator: fold, scale to radians, Taylor series by
// Horner's rule in parallel sine and cosine chains, round to Q1.17.
// Depends on arv_pkg.
module arv_sincos
    import arv_pkg::*;
#(
    parameter int ANGLE_BITS = ARV_ANGLE_BITS
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [ANGLE_BITS-1:0]    angle,
    output logic signed [TRIG_W-1:0] trig_sin,
    output logic signed [TRIG_W-1:0] trig_cos
);

    typedef struct packed {
        logic [1:0] quad;
        logic       folded;
    } oct_t;

    localparam int OCT_DEPTH = TRIG_LAT - 1;
    localparam int TH_DEPTH  = 9;
    localparam int X2_DEPTH  = 8;
    localparam int MID_STEPS = HORNER_STEPS - 1;

    localparam logic [OFS_W-1:0] OFS_HALF = OFS_W'(1) << (OFS_W - 1);
    localparam logic [OFS_W:0]   OFS_FULL = (OFS_W + 1)'(1) << OFS_W;
    localparam logic [SC_W-1:0]  Q17_HALF = SC_W'(1) << (QW - TRIG_FRAC - 1);
    localparam int TH_PROD_W = OFS_W + SC_W;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Q1.30 product, rounded half up
    function automatic logic [SC_W-1:0] qmul(input logic [SC_W-1:0] a,
                                             input logic [SC_W-1:0] b);
        logic [2*SC_W-1:0] pr;
        pr = (2*SC_W)'(a) * (2*SC_W)'(b) + ((2*SC_W)'(1) << (QW - 1));
        return pr[QW +: SC_W];
    endfunction

    // one minus the truncated quotient by a series constant
    function automatic logic [SC_W-1:0] one_minus_div(input logic [SC_W-1:0] p,
                                                      input logic [31:0] magic,
                                                      input int sh);
        logic [SC_W+31:0] pr;
        pr = (SC_W + 32)'(p) * (SC_W + 32)'(magic);
        return Q_ONE - SC_W'(pr >> sh);
    endfunction

    logic [TURN_BITS-1:0] turn;
    logic [OFS_W-1:0]     ofs;
    logic [OFS_W-1:0]     ofs_fold;
    logic                 folded;
    logic [TH_PROD_W-1:0] th_prod;

    oct_t             oct_reg  [OCT_DEPTH];
    logic [OFS_W-1:0] ofs_reg;
    logic [QW-1:0]    th_reg   [TH_DEPTH];
    logic [QW-1:0]    x2_reg   [X2_DEPTH];
    logic [SC_W-1:0]  st_reg   [HORNER_STEPS];
    logic [SC_W-1:0]  ct_reg   [HORNER_STEPS];
    logic [SC_W-1:0]  sp_reg   [MID_STEPS];
    logic [SC_W-1:0]  cp_reg   [HORNER_STEPS];
    logic [SC_W-1:0]  s30_reg;
    logic [SC_W-1:0]  s30d_reg;
    logic [SC_W-1:0]  c30_reg;

    logic [MAG_W-1:0]         s17;
    logic [MAG_W-1:0]         c17;
    logic signed [TRIG_W-1:0] s_pos;
    logic signed [TRIG_W-1:0] c_pos;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    // fold the offset onto the first octant
    assign turn     = TURN_BITS'(angle) << (TURN_BITS - ANGLE_BITS);
    assign ofs      = turn[OFS_W-1:0];
    assign folded   = ofs > OFS_HALF;
    assign ofs_fold = folded ? OFS_W'(OFS_FULL - (OFS_W + 1)'(ofs)) : ofs;

    assign th_prod = TH_PROD_W'(ofs_reg) * TH_PROD_W'(HALF_PI_Q30)
                   + (TH_PROD_W'(1) << (OFS_W - 1));

    always_comb
    begin
        s17   = MAG_W'((s30d_reg + Q17_HALF) >> (QW - TRIG_FRAC));
        c17   = MAG_W'((c30_reg + Q17_HALF) >> (QW - TRIG_FRAC));
        s_pos = oct_reg[OCT_DEPTH-1].folded ? TRIG_W'(c17) : TRIG_W'(s17);
        c_pos = oct_reg[OCT_DEPTH-1].folded ? TRIG_W'(s17) : TRIG_W'(c17);
        case (oct_reg[OCT_DEPTH-1].quad)
            QUAD_0:
            begin
                sin_next = s_pos;
                cos_next = c_pos;
            end
            QUAD_1:
            begin
                sin_next = c_pos;
                cos_next = -s_pos;
            end
            QUAD_2:
            begin
                sin_next = -s_pos;
                cos_next = -c_pos;
            end
            default:
            begin
                sin_next = -c_pos;
                cos_next = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oct_reg[0] <= '{quad: turn[TURN_BITS-1 -: 2], folded: folded};
            for (int i = 1; i < OCT_DEPTH; i++)
            begin
                oct_reg[i] <= oct_reg[i-1];
            end
            ofs_reg <= ofs_fold;

            th_reg[0] <= th_prod[OFS_W +: QW];
            for (int i = 1; i < TH_DEPTH; i++)
            begin
                th_reg[i] <= th_reg[i-1];
            end

            x2_reg[0] <= QW'(qmul(SC_W'(th_reg[0]), SC_W'(th_reg[0])));
            for (int i = 1; i < X2_DEPTH; i++)
            begin
                x2_reg[i] <= x2_reg[i-1];
            end

            // first term: x2 times one is x2 itself
            st_reg[0] <= one_minus_div(SC_W'(x2_reg[0]), SIN_MAGIC[0], SIN_SHIFT[0]);
            ct_reg[0] <= one_minus_div(SC_W'(x2_reg[0]), COS_MAGIC[0], COS_SHIFT[0]);

            // each step: multiply stage, then divide-and-subtract stage
            for (int k = 0; k < MID_STEPS; k++)
            begin
                sp_reg[k]   <= qmul(SC_W'(x2_reg[2*k+1]), st_reg[k]);
                cp_reg[k]   <= qmul(SC_W'(x2_reg[2*k+1]), ct_reg[k]);
                st_reg[k+1] <= one_minus_div(sp_reg[k], SIN_MAGIC[k+1], SIN_SHIFT[k+1]);
                ct_reg[k+1] <= one_minus_div(cp_reg[k], COS_MAGIC[k+1], COS_SHIFT[k+1]);
            end

            s30_reg              <= qmul(SC_W'(th_reg[TH_DEPTH-1]), st_reg[HORNER_STEPS-1]);
            cp_reg[MID_STEPS]    <= qmul(SC_W'(x2_reg[X2_DEPTH-1]), ct_reg[HORNER_STEPS-1]);
            s30d_reg             <= s30_reg;
            c30_reg              <= Q_ONE - (cp_reg[MID_STEPS] >> 1);
            sin_reg              <= sin_next;
            cos_reg              <= cos_next;
        end
    end

    assign trig_sin = sin_reg;
    assign trig_cos = cos_reg;

endmodule

// ----- sv/arv_lane.sv -----
`timescale 1ns / 1ps
// One output component lane: two signed products, summed exactly and
// rounded to nearest at integer scale, or the component copied through.
// Depends on arv_pkg.
module arv_lane
    import arv_pkg::*;
#(
    parameter int DATA_BITS = ARV_DATA_BITS
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic                        pass,
    input  logic signed [DATA_BITS-1:0] keep,
    input  logic signed [DATA_BITS-1:0] opa,
    input  logic signed [TRIG_W-1:0]    cfa,
    input  logic signed [DATA_BITS-1:0] opb,
    input  logic signed [TRIG_W-1:0]    cfb,
    output logic signed [DATA_BITS:0]   res
);

    localparam int PROD_W = DATA_BITS + TRIG_W;
    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(2 ** (TRIG_FRAC - 1));

    logic signed [PROD_W-1:0]    prod_a_reg;
    logic signed [PROD_W-1:0]    prod_b_reg;
    logic                        pass_reg;
    logic signed [DATA_BITS-1:0] keep_reg;
    logic signed [PROD_W:0]      sum;
    logic signed [DATA_BITS:0]   res_next;
    logic signed [DATA_BITS:0]   res_reg;

    always_comb
    begin
        sum = (PROD_W + 1)'(prod_a_reg) + (PROD_W + 1)'(prod_b_reg) + ROUND_HALF;
        // floor division by 2^17 is an arithmetic bit-select
        res_next = pass_reg ? (DATA_BITS + 1)'(keep_reg) : sum[TRIG_FRAC +: DATA_BITS + 1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= PROD_W'(opa) * PROD_W'(cfa);
            prod_b_reg <= PROD_W'(opb) * PROD_W'(cfb);
            pass_reg   <= pass;
            keep_reg   <= keep;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- sv/axis_rotate_vector.sv -----
`timescale 1ns / 1ps
// The pipeline runs from an input register through 13 sine/cosine stages and 2
// lane stages to an output register. Throughput: one word per cycle while the
// output is not stalled, set by the fully pipelined sine/cosine unit and the
// three product lanes.
// A stalled output freezes the pipeline; one word parks in the input skid.
// Reset clears the valid flags and the skid flag; payload is not reset.
module axis_rotate_vector
    import arv_pkg::*;
#(
    parameter int ANGLE_BITS = ARV_ANGLE_BITS,
    parameter int DATA_BITS  = ARV_DATA_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // angle, x_in, y_in, z_in from bit 0 up, zero padded to bytes
    input  logic [((ANGLE_BITS + 3*DATA_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // opcode
    input  logic [OP_W-1:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // x_out, y_out, z_out from bit 0 up, zero padded to bytes
    output logic [((NUM_LANES * (DATA_BITS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int IN_W       = ((ANGLE_BITS + 3*DATA_BITS + 7) / 8) * 8;
    localparam int OUT_W      = DATA_BITS + 1;
    localparam int RES_W      = NUM_LANES * OUT_W;
    localparam int TDATA_O_W  = ((RES_W + 7) / 8) * 8;
    localparam int VEC_DEPTH  = TRIG_LAT + 1;
    localparam int PIPE_DEPTH = TRIG_LAT + LANE_LAT + 2;

    logic                  adv;
    logic                  s_accept;
    logic                  skid_full_reg;
    logic                  skid_full_next;
    logic [IN_W-1:0]       skid_tdata_reg;
    logic [OP_W-1:0]       skid_tuser_reg;
    logic [IN_W-1:0]       src_data;
    logic [OP_W-1:0]       src_user;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    logic [ANGLE_BITS-1:0]       ang_reg;
    arv_op_t                     op_reg [VEC_DEPTH];
    logic signed [DATA_BITS-1:0] x_reg  [VEC_DEPTH];
    logic signed [DATA_BITS-1:0] y_reg  [VEC_DEPTH];
    logic signed [DATA_BITS-1:0] z_reg  [VEC_DEPTH];

    logic signed [TRIG_W-1:0]    trig_sin;
    logic signed [TRIG_W-1:0]    trig_cos;
    logic signed [TRIG_W-1:0]    sin_neg;
    logic signed [DATA_BITS-1:0] comp     [NUM_LANES];
    logic signed [OUT_W-1:0]     lane_res [NUM_LANES];
    logic [RES_W-1:0]            m_tdata_reg;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign src_data = skid_full_reg ? skid_tdata_reg : s_axis_tdata;
    assign src_user = skid_full_reg ? skid_tuser_reg : s_axis_tuser;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (adv)
        begin
            skid_full_next = 1'b0;
        end
        else if (s_accept)
        begin
            skid_full_next = 1'b1;
        end
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[PIPE_DEPTH-2:0], skid_full_reg || s_accept};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // park the word when the pipeline is held
        if (!adv && s_accept)
        begin
            skid_tdata_reg <= s_axis_tdata;
            skid_tuser_reg <= s_axis_tuser;
        end
        if (adv)
        begin
            ang_reg  <= src_data[ANGLE_BITS-1:0];
            op_reg[0] <= arv_op_t'(src_user);
            x_reg[0] <= src_data[ANGLE_BITS +: DATA_BITS];
            y_reg[0] <= src_data[ANGLE_BITS + DATA_BITS +: DATA_BITS];
            z_reg[0] <= src_data[ANGLE_BITS + 2*DATA_BITS +: DATA_BITS];
            for (int i = 1; i < VEC_DEPTH; i++)
            begin
                op_reg[i] <= op_reg[i-1];
                x_reg[i]  <= x_reg[i-1];
                y_reg[i]  <= y_reg[i-1];
                z_reg[i]  <= z_reg[i-1];
            end
            for (int l = 0; l < NUM_LANES; l++)
            begin
                m_tdata_reg[l*OUT_W +: OUT_W] <= lane_res[l];
            end
        end
    end

    arv_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sincos (
        .clk      (clk),
        .en       (adv),
        .angle    (ang_reg),
        .trig_sin (trig_sin),
        .trig_cos (trig_cos)
    );

    assign sin_neg = -trig_sin;
    assign comp[0] = x_reg[VEC_DEPTH-1];
    assign comp[1] = y_reg[VEC_DEPTH-1];
    assign comp[2] = z_reg[VEC_DEPTH-1];

    // lane L is the first across-axis component when the axis sits just
    // before it in cyclic x, y, z order, the second when the axis sits just after it
    for (genvar L = 0; L < NUM_LANES; L++)
    begin : g_lane
        localparam int NXT = (L + 1) % NUM_LANES;
        localparam int PRV = (L + 2) % NUM_LANES;

        logic                        pass;
        logic signed [DATA_BITS-1:0] opa;
        logic signed [DATA_BITS-1:0] opb;
        logic signed [TRIG_W-1:0]    cfa;
        logic signed [TRIG_W-1:0]    cfb;
        arv_op_t                     op;

        assign op = op_reg[VEC_DEPTH-1];

        always_comb
        begin
            pass = 1'b0;
            opa  = comp[L];
            cfa  = trig_cos;
            opb  = comp[NXT];
            cfb  = sin_neg;
            if (op == OP_PASS || op == arv_op_t'(OP_W'(L)))
            begin
                pass = 1'b1;
            end
            else if (op != arv_op_t'(OP_W'(PRV)))
            begin
                opa = comp[PRV];
                cfa = trig_sin;
                opb = comp[L];
                cfb = trig_cos;
            end
        end

        arv_lane #(
            .DATA_BITS (DATA_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (adv),
            .pass (pass),
            .keep (comp[L]),
            .opa  (opa),
            .cfa  (cfa),
            .opb  (opb),
            .cfb  (cfb),
            .res  (lane_res[L])
        );
    end

    assign s_axis_tready = !skid_full_reg;
    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = TDATA_O_W'(m_tdata_reg);

`ifndef NO_ASSERTIONS
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(!adv))
        else $error("skid filled while the pipeline was advancing");

    a_skid_drain_loads: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_full_reg) |-> vld_reg[0])
        else $error("skid drained without loading the input stage");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[TRIG_LAT] |-> (trig_sin <= TRIG_ONE && trig_sin >= -TRIG_ONE
                               && trig_cos <= TRIG_ONE && trig_cos >= -TRIG_ONE))
        else $error("sine or cosine outside unit range");
`endif

endmodule
